// ===== rtl/core/sam_pkg.sv =====
// ============================================================================
// sam_pkg
// Shared types and constants for the stack accumulator machine: sizes,
// opcodes, result kinds, sequencer states and the structs between modules.
// ============================================================================
package sam_pkg;

    // Stack sizing; the address and count widths follow from the depth.
    localparam int unsigned STACK_DEPTH = 32;
    localparam int unsigned ADDR_W      = $clog2(STACK_DEPTH);
    localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int unsigned DATA_W      = 16;
    localparam int unsigned FIELD_W     = 12;
    localparam int unsigned OPC_W       = 4;

    // Opcodes held in the top four bits of a word.
    localparam logic [OPC_W-1:0] OPC_ADD   = 4'h1;
    localparam logic [OPC_W-1:0] OPC_SUB   = 4'h2;
    localparam logic [OPC_W-1:0] OPC_LOAD  = 4'h3;
    localparam logic [OPC_W-1:0] OPC_STORE = 4'h4;
    localparam logic [OPC_W-1:0] OPC_IMM   = 4'h5;
    localparam logic [OPC_W-1:0] OPC_SHOW  = 4'hF;

    // Input item operations.
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_RUN  = 1'b1;

    // Result kinds.
    typedef enum logic [2:0] {
        KIND_PUSHED  = 3'd0,
        KIND_FULL    = 3'd1,
        KIND_SHOW    = 3'd2,
        KIND_DONE    = 3'd3,
        KIND_BADADDR = 3'd4
    } kind_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PUSH,
        ST_FETCH,
        ST_DECODE,
        ST_EXEC,
        ST_DONE
    } state_t;

    // One result beat.
    typedef struct packed {
        kind_t              kind;
        logic [DATA_W-1:0]  value;
        logic               last;
    } res_t;

    // Request to the stack memory for one cycle.
    typedef struct packed {
        logic               we;
        logic [ADDR_W-1:0]  waddr;
        logic [DATA_W-1:0]  wdata;
        logic               re;
        logic [ADDR_W-1:0]  raddr;
    } ram_req_t;

endpackage

// ===== rtl/core/sam_ram.sv =====
// ============================================================================
// sam_ram
// Generic single-write, single-read synchronous RAM with a registered read.
// The read data holds while no read is issued.
// ============================================================================
module sam_ram #(
    parameter  int unsigned WIDTH = 16,
    parameter  int unsigned DEPTH = 32,
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port; a read in the same cycle as a
    // write to the same entry returns the old contents.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/sam_outbuf.sv =====
// ============================================================================
// sam_outbuf
// Output register of the result channel. It takes a result beat from the
// sequencer whenever it is empty or being drained in the same cycle.
// ============================================================================
module sam_outbuf (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  sam_pkg::res_t                 res,
    input  logic                          res_valid,
    output logic                          res_ready,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [2:0]                    m_kind,
    output logic [sam_pkg::DATA_W-1:0]    m_value,
    output logic                          m_last
);
    import sam_pkg::*;

    logic m_valid_reg;
    res_t beat_reg;

    assign res_ready = !m_valid_reg || m_ready;

    // Valid flag of the held beat.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    // Payload of the held beat.
    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            beat_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_kind  = beat_reg.kind;
    assign m_value = beat_reg.value;
    assign m_last  = beat_reg.last;

endmodule

// ===== rtl/core/sam_ctrl.sv =====
// ============================================================================
// sam_ctrl
// Sequencer of the machine. It holds the accumulator, the stack count and
// the written flags of the stack entries, steers the stack memory and
// produces result beats. A run walks the stack top-down, a decode state and an execute state per word.
// ============================================================================
module sam_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_op,
    input  logic [sam_pkg::DATA_W-1:0]    s_data,
    output sam_pkg::ram_req_t             ram_req,
    input  logic [sam_pkg::DATA_W-1:0]    ram_rdata,
    output sam_pkg::res_t                 res,
    output logic                          res_valid,
    input  logic                          res_ready
);
    import sam_pkg::*;

    state_t               state_reg, state_next;
    logic [DATA_W-1:0]    data_reg;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [DATA_W-1:0]    acc_reg, acc_next;
    logic [STACK_DEPTH-1:0] written_reg;
    logic                 rvalid_reg;
    logic                 fwd_reg;
    logic [DATA_W-1:0]    fwd_data_reg;
    logic [OPC_W-1:0]     opc_reg;
    logic [FIELD_W-1:0]   field_reg;

    logic [DATA_W-1:0]    rd_word;
    logic [OPC_W-1:0]     dec_opc;
    logic [FIELD_W-1:0]   dec_field;
    logic                 dec_noaddr;
    logic                 dec_bad;
    logic [ADDR_W-1:0]    dec_raddr;
    logic                 stack_full;
    logic                 exec_go;
    logic                 dec_latch;

    // Read data as the logic sees it: a forwarded store, an entry never
    // written (reads as zero), or the memory contents.
    always_comb begin
        if (fwd_reg) begin
            rd_word = fwd_data_reg;
        end else if (rvalid_reg) begin
            rd_word = ram_rdata;
        end else begin
            rd_word = '0;
        end
    end

    // Decode of the top-of-stack word.
    assign dec_opc    = rd_word[DATA_W-1 -: OPC_W];
    assign dec_field  = rd_word[FIELD_W-1:0];
    assign dec_noaddr = (dec_opc == OPC_IMM) || (dec_opc == OPC_SHOW);
    assign dec_bad    = !dec_noaddr && (dec_field >= FIELD_W'(STACK_DEPTH));

    always_comb begin
        if (dec_opc == OPC_SHOW) begin
            dec_raddr = ADDR_W'(STACK_DEPTH - 1);
        end else if (dec_noaddr) begin
            dec_raddr = '0;
        end else begin
            dec_raddr = dec_field[ADDR_W-1:0];
        end
    end

    assign stack_full = (count_reg == CNT_W'(STACK_DEPTH));
    assign exec_go    = (opc_reg != OPC_SHOW) || res_ready;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = (s_op == OP_RUN) ? ST_FETCH : ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            ST_FETCH: begin
                state_next = (count_reg == '0) ? ST_DONE : ST_DECODE;
            end
            ST_DECODE: begin
                if (!dec_bad) begin
                    state_next = ST_EXEC;
                end else if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            ST_EXEC: begin
                if (exec_go) begin
                    state_next = (count_reg == CNT_W'(1)) ? ST_DONE : ST_DECODE;
                end
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs: handshake, memory requests, result beats and datapath updates.
    always_comb begin
        s_ready    = 1'b0;
        ram_req    = '0;
        res        = '{kind: KIND_DONE, value: acc_reg, last: 1'b1};
        res_valid  = 1'b0;
        count_next = count_reg;
        acc_next   = acc_reg;
        dec_latch  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            ST_PUSH: begin
                res_valid = 1'b1;
                res.value = data_reg;
                res.kind  = stack_full ? KIND_FULL : KIND_PUSHED;
                if (res_ready && !stack_full) begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = count_reg[ADDR_W-1:0];
                    ram_req.wdata = data_reg;
                    count_next    = count_reg + CNT_W'(1);
                end
            end
            ST_FETCH: begin
                if (count_reg != '0) begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = ADDR_W'(count_reg - CNT_W'(1));
                end
            end
            ST_DECODE: begin
                if (dec_bad) begin
                    res_valid = 1'b1;
                    res.kind  = KIND_BADADDR;
                    res.value = DATA_W'(dec_field);
                end else begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = dec_raddr;
                    dec_latch     = 1'b1;
                end
            end
            ST_EXEC: begin
                if (opc_reg == OPC_SHOW) begin
                    res_valid = 1'b1;
                    res.kind  = KIND_SHOW;
                    res.value = rd_word;
                    res.last  = 1'b0;
                end
                if (exec_go) begin
                    case (opc_reg)
                        OPC_ADD:   acc_next = acc_reg + rd_word;
                        OPC_SUB:   acc_next = acc_reg - rd_word;
                        OPC_LOAD:  acc_next = rd_word;
                        OPC_IMM:   acc_next = DATA_W'(field_reg);
                        default:   acc_next = acc_reg;
                    endcase
                    if (opc_reg == OPC_STORE) begin
                        ram_req.we    = 1'b1;
                        ram_req.waddr = field_reg[ADDR_W-1:0];
                        ram_req.wdata = acc_reg;
                    end
                    count_next = count_reg - CNT_W'(1);
                    // Fetch the next word while this one retires.
                    if (count_reg != CNT_W'(1)) begin
                        ram_req.re    = 1'b1;
                        ram_req.raddr = ADDR_W'(count_reg - CNT_W'(2));
                    end
                end
            end
            ST_DONE: begin
                res_valid = 1'b1;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            acc_reg     <= '0;
            written_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            acc_reg   <= acc_next;
            if (ram_req.we) begin
                written_reg[ram_req.waddr] <= 1'b1;
            end
        end
    end

    // Accepted item, decoded word, and read-side bookkeeping. A read issued
    // alongside a write to the same entry takes the written data instead.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_data;
        end
        if (dec_latch) begin
            opc_reg   <= dec_opc;
            field_reg <= dec_field;
        end
        if (ram_req.re) begin
            rvalid_reg   <= written_reg[ram_req.raddr];
            fwd_reg      <= ram_req.we && (ram_req.waddr == ram_req.raddr);
            fwd_data_reg <= ram_req.wdata;
        end
    end

endmodule

// ===== rtl/core/stack_accumulator_machine_top.sv =====
// ============================================================================
// stack_accumulator_machine_top
// 16-bit accumulator machine whose memory is a bounded stack of words.
//
//   Channel | Ports                       | Beat carries
//   --------+-----------------------------+------------------------------------
//   input   | s_valid s_ready s_op s_data | push a word, or run the stack
//   result  | m_valid m_ready m_kind      | pushed/full/display/done/bad addr,
//           | m_value m_last              | value, last beat of the item
//
// A push gives its result from the PUSH state via the result register. A run
// passes FETCH, then DECODE and EXEC per word executed, then DONE, set by the
// single read port of the stack memory: each word needs one read for itself
// and one for its operand. Reset clears the stack count, accumulator and
// per-entry written flags directly; no clearing pass runs. A stalled result
// channel holds the sequencer; a new item is taken while a result still waits.
// ============================================================================
module stack_accumulator_machine_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_op,
    input  logic [sam_pkg::DATA_W-1:0]    s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [2:0]                    m_kind,
    output logic [sam_pkg::DATA_W-1:0]    m_value,
    output logic                          m_last
);
    import sam_pkg::*;

    ram_req_t          ram_req;
    logic [DATA_W-1:0] ram_rdata;
    res_t              res;
    logic              res_valid;
    logic              res_ready;

    // Sequencer.
    sam_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_op      (s_op),
        .s_data    (s_data),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata),
        .res       (res),
        .res_valid (res_valid),
        .res_ready (res_ready)
    );

    // Stack memory.
    sam_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .aclk  (aclk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    // Result register.
    sam_outbuf u_outbuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res       (res),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_kind    (m_kind),
        .m_value   (m_value),
        .m_last    (m_last)
    );

endmodule

// ===== rtl/core/sam_checker.sv =====
// ============================================================================
// sam_checker
// Port-level checks of the stack accumulator machine, bound to the top level.
// ============================================================================
module sam_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [2:0]                    m_kind,
    input logic [sam_pkg::DATA_W-1:0]    m_value,
    input logic                          m_last
);
    import sam_pkg::*;

    // A stalled result beat holds its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_value)
            && $stable(m_last))
        else $error("result beat changed while stalled");

    // Display beats never end an item; every other kind does.
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last == (m_kind != KIND_SHOW)))
        else $error("last flag does not match result kind");

    // The block is never ready again in the cycle after it takes an item.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second item taken straight after the first");

    // Reset leaves the result channel empty.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid straight after reset");

endmodule

bind stack_accumulator_machine_top sam_checker u_sam_checker (.*);

// ===== verif/tb_stack_accumulator_machine_top.sv =====
// ============================================================================
// tb_stack_accumulator_machine_top
// Self-checking testbench for the stack accumulator machine. A short table of
// directed beats covers the extremes, every opcode, bad addresses and the
// empty run. Random programs with random content follow: full stacks, refused
// pushes and noise words. A behavioural model of the stack, count and
// accumulator predicts every result beat, and a checker compares the beats
// in order. Both channels idle in random bursts.
// ============================================================================
module tb_stack_accumulator_machine_top;

    import sam_pkg::*;

    localparam int DIRECTED_COUNT = 25;
    localparam int RANDOM_ITEMS   = 240;
    localparam int QUIET_ITEMS    = 40;
    localparam int LONG_HOLD      = 250;
    localparam int DRAIN_CYCLES   = 100;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS    = 10;

    // One row of the directed table; expected is typed in only where flagged.
    typedef struct {
        logic              op;
        logic [DATA_W-1:0] data;
        bit                typed;
        kind_t             kind;
        logic [DATA_W-1:0] value;
    } stim_row_t;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic              s_op;
    logic [DATA_W-1:0] s_data;
    logic              m_valid;
    logic              m_ready;
    logic [2:0]        m_kind;
    logic [DATA_W-1:0] m_value;
    logic              m_last;

    // Model of the machine state.
    logic [DATA_W-1:0] machine_mem [STACK_DEPTH];
    int                machine_count;
    logic [DATA_W-1:0] machine_acc;

    res_t expected_beats [$];
    res_t step_beats [$];

    int error_count;
    int items_sent;
    int idle_cycles;
    bit quiet;
    bit hold_req;

    // Directed table: extremes, every opcode, wrap, bad addresses, recovery.
    stim_row_t directed_rows [DIRECTED_COUNT] = '{
        '{OP_RUN,  16'h0000, 1'b1, KIND_DONE,    16'h0000},
        '{OP_PUSH, 16'h0000, 1'b1, KIND_PUSHED,  16'h0000},
        '{OP_PUSH, 16'h6005, 1'b1, KIND_PUSHED,  16'h6005},
        '{OP_PUSH, 16'h3001, 1'b1, KIND_PUSHED,  16'h3001},
        '{OP_PUSH, 16'h201F, 1'b1, KIND_PUSHED,  16'h201F},
        '{OP_PUSH, 16'h101F, 1'b1, KIND_PUSHED,  16'h101F},
        '{OP_PUSH, 16'hFFFF, 1'b1, KIND_PUSHED,  16'hFFFF},
        '{OP_PUSH, 16'h401F, 1'b1, KIND_PUSHED,  16'h401F},
        '{OP_PUSH, 16'h5FFF, 1'b1, KIND_PUSHED,  16'h5FFF},
        '{OP_RUN,  16'hFFFF, 1'b0, KIND_PUSHED,  16'h0000},
        '{OP_PUSH, 16'h1005, 1'b1, KIND_PUSHED,  16'h1005},
        '{OP_PUSH, 16'h5000, 1'b1, KIND_PUSHED,  16'h5000},
        '{OP_RUN,  16'h0000, 1'b0, KIND_PUSHED,  16'h0000},
        '{OP_PUSH, 16'h1005, 1'b1, KIND_PUSHED,  16'h1005},
        '{OP_RUN,  16'h0000, 1'b0, KIND_PUSHED,  16'h0000},
        '{OP_PUSH, 16'h1020, 1'b1, KIND_PUSHED,  16'h1020},
        '{OP_RUN,  16'h0000, 1'b1, KIND_BADADDR, 16'h0020},
        '{OP_PUSH, 16'hEFFF, 1'b1, KIND_PUSHED,  16'hEFFF},
        '{OP_RUN,  16'h0000, 1'b1, KIND_BADADDR, 16'h0FFF},
        '{OP_PUSH, 16'h4001, 1'b1, KIND_PUSHED,  16'h4001},
        '{OP_PUSH, 16'h5000, 1'b1, KIND_PUSHED,  16'h5000},
        '{OP_RUN,  16'h0000, 1'b0, KIND_PUSHED,  16'h0000},
        '{OP_PUSH, 16'h4000, 1'b1, KIND_PUSHED,  16'h4000},
        '{OP_PUSH, 16'h5000, 1'b1, KIND_PUSHED,  16'h5000},
        '{OP_RUN,  16'h0000, 1'b0, KIND_PUSHED,  16'h0000}
    };

    stack_accumulator_machine_top i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_op    (s_op),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_kind  (m_kind),
        .m_value (m_value),
        .m_last  (m_last)
    );

    // Clock, period 12.
    initial aclk = 1'b0;
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Work out the result beats of one accepted input beat into step_beats.
    task automatic execute_item(input logic op, input logic [DATA_W-1:0] data);
        logic [DATA_W-1:0]  word;
        logic [OPC_W-1:0]   opc;
        logic [FIELD_W-1:0] field;
        logic [FIELD_W-1:0] addr;
        bit                 stopped;
        step_beats.delete();
        if (op == OP_PUSH) begin
            if (machine_count >= int'(STACK_DEPTH)) begin
                step_beats.push_back('{kind: KIND_FULL, value: data, last: 1'b1});
            end else begin
                machine_mem[machine_count] = data;
                machine_count++;
                step_beats.push_back('{kind: KIND_PUSHED, value: data, last: 1'b1});
            end
        end else begin
            stopped = 1'b0;
            // Execute from the top of the stack downwards, popping each word.
            while (machine_count > 0 && !stopped) begin
                word  = machine_mem[machine_count-1];
                opc   = word[DATA_W-1:FIELD_W];
                field = word[FIELD_W-1:0];
                addr  = (opc == OPC_IMM || opc == OPC_SHOW) ? '0 : field;
                if (addr >= STACK_DEPTH) begin
                    // The offending word stays on the stack.
                    step_beats.push_back('{kind: KIND_BADADDR, value: DATA_W'(addr),
                                           last: 1'b1});
                    stopped = 1'b1;
                end else begin
                    case (opc)
                        OPC_ADD:   machine_acc = machine_acc + machine_mem[addr];
                        OPC_SUB:   machine_acc = machine_acc - machine_mem[addr];
                        OPC_LOAD:  machine_acc = machine_mem[addr];
                        OPC_STORE: machine_mem[addr] = machine_acc;
                        OPC_IMM:   machine_acc = DATA_W'(field);
                        OPC_SHOW: begin
                            step_beats.push_back('{kind: KIND_SHOW,
                                                   value: machine_mem[STACK_DEPTH-1],
                                                   last: 1'b0});
                        end
                        default: ;
                    endcase
                    machine_count--;
                end
            end
            if (!stopped) begin
                step_beats.push_back('{kind: KIND_DONE, value: machine_acc, last: 1'b1});
            end
        end
    endtask

    // Offer one beat, wait for acceptance, then record what it should cause.
    task automatic send_item(input logic op, input logic [DATA_W-1:0] data,
                             input bit typed, input res_t typed_beat);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_op    <= op;
        s_data  <= data;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        execute_item(op, data);
        if (typed) begin
            expected_beats.push_back(typed_beat);
        end else begin
            foreach (step_beats[i]) expected_beats.push_back(step_beats[i]);
        end
    endtask

    // Random program word whose address, where it has one, is in range.
    function automatic logic [DATA_W-1:0] program_word(input bit allow_store);
        logic [OPC_W-1:0]   opc;
        logic [FIELD_W-1:0] field;
        if ($urandom_range(0, 1) == 1) begin
            case ($urandom_range(0, 5))
                0:       opc = OPC_ADD;
                1:       opc = OPC_SUB;
                2:       opc = OPC_LOAD;
                3:       opc = OPC_STORE;
                4:       opc = OPC_IMM;
                default: opc = OPC_SHOW;
            endcase
        end else begin
            opc = OPC_W'($urandom_range(0, 15));
        end
        if (!allow_store && opc == OPC_STORE) opc = OPC_ADD;
        if (opc == OPC_IMM || opc == OPC_SHOW) begin
            field = FIELD_W'($urandom);
        end else begin
            field = FIELD_W'($urandom_range(0, STACK_DEPTH-1));
        end
        return {opc, field};
    endfunction

    // A stopped run leaves a bad word on top; overwrite it with a no-op and
    // run again until the stack is empty. There are always two free slots.
    task automatic clear_bad_words();
        int slot;
        while (machine_count > 0) begin
            slot = machine_count - 1;
            send_item(OP_PUSH, {OPC_STORE, FIELD_W'(slot)}, 1'b0, '0);
            send_item(OP_PUSH, {OPC_IMM, FIELD_W'(0)}, 1'b0, '0);
            send_item(OP_RUN, '0, 1'b0, '0);
        end
    endtask

    // Fill the stack with safe words, try to overfill it, then run it.
    task automatic full_stack_program();
        for (int i = 0; i < int'(STACK_DEPTH); i++) begin
            send_item(OP_PUSH, program_word(1'b0), 1'b0, '0);
        end
        repeat ($urandom_range(1, 2)) send_item(OP_PUSH, DATA_W'($urandom), 1'b0, '0);
        send_item(OP_RUN, DATA_W'($urandom), 1'b0, '0);
    endtask

    // Short program, with noise words if asked, topped out two slots below full.
    task automatic short_program(input bit with_noise);
        int len;
        len = $urandom_range(1, 8);
        if (len > int'(STACK_DEPTH) - 2 - machine_count) begin
            len = int'(STACK_DEPTH) - 2 - machine_count;
        end
        for (int i = 0; i < len; i++) begin
            if (with_noise && $urandom_range(0, 3) == 0) begin
                send_item(OP_PUSH, DATA_W'($urandom), 1'b0, '0);
            end else begin
                send_item(OP_PUSH, program_word(1'b1), 1'b0, '0);
            end
        end
        send_item(OP_RUN, DATA_W'($urandom), 1'b0, '0);
    endtask

    // Count errors; only the first few are shown in detail.
    function automatic void report_mismatch(input string what, input res_t want);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("%s: expected kind %0d value %h last %0d, got kind %0d value %h last %0d",
                     what, want.kind, want.value, want.last, m_kind, m_value, m_last);
        end
    endfunction

    // Compare each accepted result beat with the oldest expectation.
    always @(posedge aclk) begin : result_check
        res_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_beats.size() == 0) begin
                report_mismatch("unexpected result", '0);
            end else begin
                want = expected_beats.pop_front();
                if (m_kind !== want.kind || m_value !== want.value || m_last !== want.last) begin
                    report_mismatch("result mismatch", want);
                end
            end
        end
    end

    // Cycles in which neither channel moves a beat.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : watchdog
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("tb_stack_accumulator_machine_top: errors");
        $finish;
    end

    // Result side: random ready and stall bursts, one long hold on request.
    initial begin : result_sink
        bit stall;
        bit hold_done;
        hold_done = 1'b0;
        m_ready = 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if (hold_req && !hold_done) begin
                m_ready <= 1'b0;
                hold_done = 1'b1;
                repeat (LONG_HOLD) @(posedge aclk);
            end else if (quiet) begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end else begin
                stall = ($urandom_range(0, 2) == 0);
                m_ready <= !stall;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
        end
    end

    // Stimulus: reset, directed table, then random programs.
    initial begin : stimulus
        bit   hold_fired;
        bit   pause_fired;
        res_t row_beat;
        int   pick;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_op          = OP_PUSH;
        s_data        = '0;
        quiet         = 1'b0;
        hold_req      = 1'b0;
        hold_fired    = 1'b0;
        pause_fired   = 1'b0;
        error_count   = 0;
        items_sent    = 0;
        machine_count = 0;
        machine_acc   = '0;
        foreach (machine_mem[i]) machine_mem[i] = '0;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            row_beat = '{kind: directed_rows[i].kind, value: directed_rows[i].value,
                         last: 1'b1};
            send_item(directed_rows[i].op, directed_rows[i].data,
                      directed_rows[i].typed, row_beat);
        end

        // Push when full is reached at once by a full-stack program.
        full_stack_program();

        while (items_sent < DIRECTED_COUNT + RANDOM_ITEMS) begin
            if (items_sent >= DIRECTED_COUNT + RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
            if (!hold_fired && items_sent >= DIRECTED_COUNT + 100) begin
                hold_req   = 1'b1;
                hold_fired = 1'b1;
            end
            if (!pause_fired && items_sent >= DIRECTED_COUNT + 180) begin
                // Let the machine drain completely before carrying on.
                s_valid <= 1'b0;
                while (expected_beats.size() != 0) @(posedge aclk);
                @(posedge aclk);
                pause_fired = 1'b1;
            end
            pick = $urandom_range(0, 9);
            if (pick == 0 && machine_count == 0) begin
                full_stack_program();
            end else if (pick <= 6) begin
                short_program(1'b0);
            end else if (pick <= 8) begin
                short_program(1'b1);
            end else begin
                // Loose noise words left on the stack, or a bare run.
                if ($urandom_range(0, 1) == 1 && machine_count <= int'(STACK_DEPTH) - 3) begin
                    send_item(OP_PUSH, DATA_W'($urandom), 1'b0, '0);
                end else begin
                    send_item(OP_RUN, DATA_W'($urandom), 1'b0, '0);
                end
            end
            clear_bad_words();
        end

        s_valid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0 && expected_beats.size() == 0) begin
            $display("tb_stack_accumulator_machine_top: clean");
        end else begin
            $display("tb_stack_accumulator_machine_top: errors");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/sam_pkg.sv
rtl/core/sam_ram.sv
rtl/core/sam_outbuf.sv
rtl/core/sam_ctrl.sv
rtl/core/stack_accumulator_machine_top.sv
rtl/core/sam_checker.sv
verif/tb_stack_accumulator_machine_top.sv
